// ----- rtl/core/bcbr_pkg.sv -----
// ----------------------------------------------------------------------------
// bcbr_pkg
// shared types, widths and helpers for the box crop bilinear resampler
// ----------------------------------------------------------------------------
package bcbr_pkg;

   localparam int VALUE_W        = 16;
   localparam int PIXEL_INDEX_W  = 14;
   localparam int CHAN_W         = 2;
   localparam int TOP_W          = 7;
   localparam int BOTTOM_W       = 8;
   localparam int OUT_POS_W      = 6;

   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 8;

   // position divider
   localparam int DIV_W          = 7;
   localparam int MAG_W          = 14;
   localparam int STEP_W         = 8;
   localparam int FRAC_W         = 16;
   localparam int DVD_W          = 32;
   localparam int QUOT_W         = 32;
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_CYCLES     = DVD_W / DIV_RADIX_BITS;

   // geometry and blending
   localparam int POS_W          = 33;
   localparam int FL_W           = POS_W - FRAC_W;
   localparam int COORD_W        = 10;
   localparam int SIZE_W         = 11;
   localparam int WEIGHT_W       = 33;
   localparam int ACC_W          = 48;

   localparam logic [1:0] NBR_LAST = 2'd3;

   // result queue
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_W     = 3;
   localparam int FIFO_CNT_W     = 4;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } operation_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_OUT_WIDTH     = 3'd3,
      CSR_OUT_HEIGHT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic             bypass;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic idle;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [FRAC_W-1:0]  wlo;
      logic               hit;
   } nbr_type;

   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic [CHAN_W-1:0]  sample_channel;
      logic               last_channel;
      logic               clamped;
   } rsp_item_type;

   // floor/ceiling neighbours of a signed 17.16 position, clamped to 0..size-1
   function automatic nbr_type bcbr_neighbours(input logic signed [POS_W-1:0] pos,
                                               input logic [SIZE_W-1:0] size);
      logic signed [FL_W-1:0] fl;
      logic signed [FL_W-1:0] ce;
      logic signed [FL_W-1:0] lim;
      logic [FRAC_W-1:0]      frac;
      nbr_type                r;
      fl    = pos[POS_W-1:FRAC_W];
      frac  = pos[FRAC_W-1:0];
      ce    = fl + ((frac != '0) ? FL_W'(1) : FL_W'(0));
      lim   = $signed({{(FL_W-SIZE_W){1'b0}}, size}) - FL_W'(1);
      r.hit = 1'b0;
      r.wlo = FRAC_W'(0) - frac;
      if (fl[FL_W-1]) begin
         r.lo  = '0;
         r.hit = 1'b1;
      end else if (fl > lim) begin
         r.lo  = COORD_W'(lim);
         r.hit = 1'b1;
      end else begin
         r.lo = COORD_W'(fl);
      end
      if (ce[FL_W-1]) begin
         r.hi  = '0;
         r.hit = 1'b1;
      end else if (ce > lim) begin
         r.hi  = COORD_W'(lim);
         r.hit = 1'b1;
      end else begin
         r.hi = COORD_W'(ce);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/bcbr_req_if.sv -----
// ----------------------------------------------------------------------------
// bcbr_req_if
// request channel: image writes and sample requests
// ----------------------------------------------------------------------------
interface bcbr_req_if
   import bcbr_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     operation;
   logic [PIXEL_INDEX_W-1:0] pixel_index;
   logic [CHAN_W-1:0]        write_channel;
   logic [VALUE_W-1:0]       write_value;
   logic [TOP_W-1:0]         box_top;
   logic [TOP_W-1:0]         box_left;
   logic [BOTTOM_W-1:0]      box_bottom;
   logic [BOTTOM_W-1:0]      box_right;
   logic [OUT_POS_W-1:0]     out_row;
   logic [OUT_POS_W-1:0]     out_col;

   modport source (
      output valid, operation, pixel_index, write_channel, write_value,
             box_top, box_left, box_bottom, box_right, out_row, out_col,
      input  ready
   );

   modport sink (
      input  valid, operation, pixel_index, write_channel, write_value,
             box_top, box_left, box_bottom, box_right, out_row, out_col,
      output ready
   );
endinterface

// ----- rtl/core/bcbr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bcbr_rsp_if
// response channel: one blended value per channel
// ----------------------------------------------------------------------------
interface bcbr_rsp_if
   import bcbr_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] sample_value;
   logic [CHAN_W-1:0]  sample_channel;
   logic               last_channel;
   logic               clamped;

   modport source (
      output valid, sample_value, sample_channel, last_channel, clamped,
      input  ready
   );

   modport sink (
      input  valid, sample_value, sample_channel, last_channel, clamped,
      output ready
   );
endinterface

// ----- rtl/core/bcbr_div.sv -----
// ----------------------------------------------------------------------------
// bcbr_div
// radix-16 restoring divider giving floor((+/-mag << 16) / divisor)
// ----------------------------------------------------------------------------
module bcbr_div
   import bcbr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  div_req_type              req,
   input  logic                     take,
   output div_stat_type             stat,
   output logic signed [QUOT_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_CYCLES);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_FIX,
      S_DONE
   } state_type;

   state_type                state_ff;
   logic [DVD_W-1:0]         dvd_ff;
   logic [QUOT_W-1:0]        quo_ff;
   logic [DIV_W:0]           rem_ff;
   logic [DIV_W-1:0]         dsr_ff;
   logic                     neg_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [QUOT_W-1:0] quot_ff;

   logic [DVD_W-1:0]         dvd_in;
   logic [QUOT_W-1:0]        quo_in;
   logic [DIV_W:0]           rem_in;

   // four quotient bits per cycle
   always_comb begin
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         rem_in = {rem_in[DIV_W-1:0], dvd_in[DVD_W-1]};
         dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
         if (rem_in >= {1'b0, dsr_ff}) begin
            rem_in = rem_in - {1'b0, dsr_ff};
            quo_in = {quo_in[QUOT_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_in[QUOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  dvd_ff <= {{(DVD_W-MAG_W-FRAC_W){1'b0}}, req.mag, {FRAC_W{1'b0}}};
                  quo_ff <= '0;
                  rem_ff <= '0;
                  dsr_ff <= req.divisor;
                  neg_ff <= req.neg;
                  cnt_ff <= '0;
                  if (req.bypass) begin
                     quot_ff  <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_RUN;
                  end
               end
            end
            S_RUN: begin
               dvd_ff <= dvd_in;
               quo_ff <= quo_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_ff <= S_FIX;
               end
            end
            S_FIX: begin
               // negative numerator rounds toward minus infinity
               quot_ff  <= neg_ff ? QUOT_W'(-(quo_ff + QUOT_W'(rem_ff != '0))) : quo_ff;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);
   assign quot      = quot_ff;

endmodule

// ----- rtl/core/box_crop_bilinear_resample.sv -----
// ----------------------------------------------------------------------------
// box_crop_bilinear_resample
// crop-and-resize sampler over an on-chip interleaved image memory
// ----------------------------------------------------------------------------
// An image is loaded one channel value per write transaction into a single
// port memory of MAX_WIDTH*MAX_HEIGHT*CHANNELS 16-bit entries (no clearing,
// entries must be written before a sample reads them). A sample transaction
// gives a box and an output row/column; two radix-16 dividers work out the
// signed 17.16 source position, then a fetch engine reads the four
// neighbours of each channel in use, one memory read per cycle once the
// channel has a reserved queue slot, and returns one response transaction
// per channel. The sustained sample rate is set by the memory port with
// three channels; with one or two channels the divider pass sets it
// instead, unless the patch size is below two and the divide is skipped.
// Divide and geometry of the next sample overlap the fetch of the current
// one, and the next fetch starts right after the last read of the current
// one. A write waits until every earlier sample has issued all its reads.
// Responses queue in an 8-entry buffer, so the request side keeps moving
// while the response side stalls, until that buffer's slots are all taken.
// ----------------------------------------------------------------------------
module box_crop_bilinear_resample
   import bcbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int CHANNELS   = 3,
   parameter int MAX_OUT    = 64
)(
   input  logic                   clock,
   input  logic                   reset,
   bcbr_req_if.sink               req_chan,
   bcbr_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int PIXELS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int DEPTH   = PIXELS * CHANNELS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PIX_W   = $clog2(PIXELS);
   localparam int X_W     = $clog2(MAX_WIDTH);
   localparam int Y_W     = $clog2(MAX_HEIGHT);
   localparam int WSIZE_W = $clog2(MAX_WIDTH + 1);
   localparam int HSIZE_W = $clog2(MAX_HEIGHT + 1);
   localparam int K_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int WH_W    = FRAC_W + 1;

   // ---------------------------------------------------------------- config
   logic [7:0]       image_width_ff;
   logic [7:0]       image_height_ff;
   logic [1:0]       channel_count_ff;
   logic [DIV_W-1:0] out_width_ff;
   logic [DIV_W-1:0] out_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= 8'd128;
         image_height_ff  <= 8'd128;
         channel_count_ff <= 2'd3;
         out_width_ff     <= 7'd16;
         out_height_ff    <= 7'd16;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_write_data;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_write_data;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_write_data[1:0];
            CSR_OUT_WIDTH:     out_width_ff     <= csr_write_data[DIV_W-1:0];
            CSR_OUT_HEIGHT:    out_height_ff    <= csr_write_data[DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes after saturation
   logic [WSIZE_W-1:0] w_eff;
   logic [HSIZE_W-1:0] h_eff;
   logic [K_W-1:0]     k_last;
   logic [DIV_W-1:0]   ow_sat;
   logic [DIV_W-1:0]   oh_sat;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WSIZE_W'(1);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WSIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = WSIZE_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = HSIZE_W'(1);
      end else if (int'(image_height_ff) > MAX_HEIGHT) begin
         h_eff = HSIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = HSIZE_W'(image_height_ff);
      end
      if (channel_count_ff == '0) begin
         k_last = '0;
      end else if (int'(channel_count_ff) > CHANNELS) begin
         k_last = K_W'(CHANNELS - 1);
      end else begin
         k_last = K_W'(channel_count_ff - 2'd1);
      end
      ow_sat = (int'(out_width_ff) > MAX_OUT) ? DIV_W'(MAX_OUT) : out_width_ff;
      oh_sat = (int'(out_height_ff) > MAX_OUT) ? DIV_W'(MAX_OUT) : out_height_ff;
   end

   // ---------------------------------------------------------- stage valids
   logic p_v_ff;
   logic geo_v_ff;
   logic job_v_ff;

   div_stat_type divy_stat;
   div_stat_type divx_stat;

   // ----------------------------------------------------------- request side
   logic is_sample;
   logic write_ok;
   logic req_accept;
   logic sample_acc;
   logic write_acc;
   logic mem_we;

   assign is_sample = (req_chan.operation == OP_SAMPLE);
   // a write waits until all earlier samples have issued their reads
   assign write_ok  = !p_v_ff && divy_stat.idle && divx_stat.idle && !geo_v_ff && !job_v_ff;
   assign req_chan.ready = is_sample ? !p_v_ff : write_ok;
   assign req_accept = req_chan.valid && req_chan.ready;
   assign sample_acc = req_accept && is_sample;
   assign write_acc  = req_accept && !is_sample;
   assign mem_we     = write_acc && (int'(req_chan.pixel_index) < PIXELS)
                       && (int'(req_chan.write_channel) < CHANNELS);

   // signed steps of the box
   logic signed [9:0] step_y;
   logic signed [9:0] step_x;

   assign step_y = $signed({2'b0, req_chan.box_bottom}) - $signed({3'b0, req_chan.box_top})
                   - 10'sd1;
   assign step_x = $signed({2'b0, req_chan.box_right}) - $signed({3'b0, req_chan.box_left})
                   - 10'sd1;

   // ------------------------------------------------------------- prep stage
   logic [TOP_W-1:0]     p_top_ff;
   logic [TOP_W-1:0]     p_left_ff;
   logic [OUT_POS_W-1:0] p_row_ff;
   logic [OUT_POS_W-1:0] p_col_ff;
   logic                 p_negy_ff;
   logic                 p_negx_ff;
   logic [STEP_W-1:0]    p_absy_ff;
   logic [STEP_W-1:0]    p_absx_ff;
   logic                 launch;

   assign launch = p_v_ff && divy_stat.idle && divx_stat.idle;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (sample_acc) begin
         p_v_ff <= 1'b1;
      end else if (launch) begin
         p_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         p_top_ff  <= req_chan.box_top;
         p_left_ff <= req_chan.box_left;
         p_row_ff  <= req_chan.out_row;
         p_col_ff  <= req_chan.out_col;
         p_negy_ff <= step_y[9];
         p_negx_ff <= step_x[9];
         p_absy_ff <= step_y[9] ? STEP_W'(-step_y) : STEP_W'(step_y);
         p_absx_ff <= step_x[9] ? STEP_W'(-step_x) : STEP_W'(step_x);
      end
   end

   // ---------------------------------------------------------------- divide
   div_req_type              divy_req;
   div_req_type              divx_req;
   logic signed [QUOT_W-1:0] quot_y;
   logic signed [QUOT_W-1:0] quot_x;
   logic [MAG_W-1:0]         mag_y;
   logic [MAG_W-1:0]         mag_x;
   logic [TOP_W-1:0]         ds_top_ff;
   logic [TOP_W-1:0]         ds_left_ff;
   logic                     geo_load;
   logic                     job_take;

   // row times |step| fits 14 bits
   assign mag_y = p_row_ff * p_absy_ff;
   assign mag_x = p_col_ff * p_absx_ff;

   always_comb begin
      divy_req.mag     = mag_y;
      divy_req.neg     = p_negy_ff;
      divy_req.bypass  = (oh_sat < DIV_W'(2));
      divy_req.divisor = oh_sat - 1'b1;
      divx_req.mag     = mag_x;
      divx_req.neg     = p_negx_ff;
      divx_req.bypass  = (ow_sat < DIV_W'(2));
      divx_req.divisor = ow_sat - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         ds_top_ff  <= p_top_ff;
         ds_left_ff <= p_left_ff;
      end
   end

   bcbr_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (launch),
      .req   (divy_req),
      .take  (geo_load),
      .stat  (divy_stat),
      .quot  (quot_y)
   );

   bcbr_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (launch),
      .req   (divx_req),
      .take  (geo_load),
      .stat  (divx_stat),
      .quot  (quot_x)
   );

   // -------------------------------------------------------------- geometry
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_x;
   nbr_type                 nb_y;
   nbr_type                 nb_x;

   logic [Y_W-1:0]    g_y0_ff;
   logic [Y_W-1:0]    g_y1_ff;
   logic [X_W-1:0]    g_x0_ff;
   logic [X_W-1:0]    g_x1_ff;
   logic [FRAC_W-1:0] g_wy_ff;
   logic [FRAC_W-1:0] g_wx_ff;
   logic              g_hit_ff;
   logic              job_done;

   // next job loads when no job is held, or on the cycle the current one issues its last read
   assign job_take = geo_v_ff && (!job_v_ff || job_done);
   assign geo_load = divy_stat.done && divx_stat.done && (!geo_v_ff || job_take);

   // signed 17.16 position: box start plus the quotient
   assign pos_y = $signed({{(POS_W-TOP_W-FRAC_W){1'b0}}, ds_top_ff, {FRAC_W{1'b0}}})
                  + $signed({quot_y[QUOT_W-1], quot_y});
   assign pos_x = $signed({{(POS_W-TOP_W-FRAC_W){1'b0}}, ds_left_ff, {FRAC_W{1'b0}}})
                  + $signed({quot_x[QUOT_W-1], quot_x});

   assign nb_y = bcbr_neighbours(pos_y, SIZE_W'(h_eff));
   assign nb_x = bcbr_neighbours(pos_x, SIZE_W'(w_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         geo_v_ff <= 1'b0;
      end else if (geo_load) begin
         geo_v_ff <= 1'b1;
      end else if (job_take) begin
         geo_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (geo_load) begin
         g_y0_ff  <= nb_y.lo[Y_W-1:0];
         g_y1_ff  <= nb_y.hi[Y_W-1:0];
         g_x0_ff  <= nb_x.lo[X_W-1:0];
         g_x1_ff  <= nb_x.hi[X_W-1:0];
         g_wy_ff  <= nb_y.wlo;
         g_wx_ff  <= nb_x.wlo;
         g_hit_ff <= nb_y.hit || nb_x.hit;
      end
   end

   // ------------------------------------------------ job: addresses, weights
   logic [WH_W-1:0]     wy_lo;
   logic [WH_W-1:0]     wy_hi;
   logic [WH_W-1:0]     wx_lo;
   logic [WH_W-1:0]     wx_hi;
   logic [2*WH_W-1:0]   w00;
   logic [2*WH_W-1:0]   w10;
   logic [2*WH_W-1:0]   w01;
   logic [2*WH_W-1:0]   w11;

   logic [PIX_W-1:0]    j_pix_ff [4];
   logic [WEIGHT_W-1:0] j_w_ff [4];
   logic                j_hit_ff;
   logic [1:0]          j_ff;
   logic [K_W-1:0]      k_ff;

   assign wy_lo = {1'b0, g_wy_ff};
   assign wx_lo = {1'b0, g_wx_ff};
   assign wy_hi = WH_W'(1 << FRAC_W) - wy_lo;
   assign wx_hi = WH_W'(1 << FRAC_W) - wx_lo;
   assign w00   = wx_lo * wy_lo;
   assign w10   = wx_lo * wy_hi;
   assign w01   = wx_hi * wy_lo;
   assign w11   = wx_hi * wy_hi;

   always_ff @(posedge clock) begin
      if (job_take) begin
         j_pix_ff[0] <= PIX_W'(int'(g_y0_ff) * int'(w_eff) + int'(g_x0_ff));
         j_pix_ff[1] <= PIX_W'(int'(g_y1_ff) * int'(w_eff) + int'(g_x0_ff));
         j_pix_ff[2] <= PIX_W'(int'(g_y0_ff) * int'(w_eff) + int'(g_x1_ff));
         j_pix_ff[3] <= PIX_W'(int'(g_y1_ff) * int'(w_eff) + int'(g_x1_ff));
         j_w_ff[0]   <= w00[WEIGHT_W-1:0];
         j_w_ff[1]   <= w10[WEIGHT_W-1:0];
         j_w_ff[2]   <= w01[WEIGHT_W-1:0];
         j_w_ff[3]   <= w11[WEIGHT_W-1:0];
         j_hit_ff    <= g_hit_ff;
      end
   end

   // ---------------------------------------------------------- fetch engine
   logic [FIFO_CNT_W-1:0] fifo_cnt_ff;
   logic [FIFO_CNT_W-1:0] inflight_ff;
   logic                  room;
   logic                  issue;
   logic [ADDR_W-1:0]     raddr;
   logic [ADDR_W-1:0]     waddr;

   // a channel starts only when its response has a reserved queue slot
   assign room     = ({1'b0, fifo_cnt_ff} + {1'b0, inflight_ff})
                     < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
   assign issue    = job_v_ff && ((j_ff != '0) || room);
   assign job_done = issue && (j_ff == NBR_LAST) && (k_ff == k_last);
   assign raddr    = ADDR_W'(int'(j_pix_ff[j_ff]) * CHANNELS + int'(k_ff));
   assign waddr    = ADDR_W'(int'(req_chan.pixel_index) * CHANNELS
                             + int'(req_chan.write_channel));

   always_ff @(posedge clock) begin
      if (reset) begin
         job_v_ff <= 1'b0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         if (job_take) begin
            job_v_ff <= 1'b1;
         end else if (job_done) begin
            job_v_ff <= 1'b0;
         end
         if (issue) begin
            j_ff <= j_ff + 1'b1;
            if (j_ff == NBR_LAST) begin
               k_ff <= (k_ff == k_last) ? '0 : k_ff + 1'b1;
            end
         end
      end
   end

   // image memory, one access per cycle, writes never meet reads
   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= req_chan.write_value;
      end else if (issue) begin
         rd_data_ff <= mem[raddr];
      end
   end

   // read stage: tag travels with the read
   logic                t1_v_ff;
   logic [1:0]          t1_j_ff;
   logic [K_W-1:0]      t1_k_ff;
   logic                t1_last_ff;
   logic                t1_hit_ff;
   logic [WEIGHT_W-1:0] t1_w_ff;

   // multiply stage
   logic                        t2_v_ff;
   logic [1:0]                  t2_j_ff;
   logic [K_W-1:0]              t2_k_ff;
   logic                        t2_last_ff;
   logic                        t2_hit_ff;
   logic [VALUE_W+WEIGHT_W-1:0] prod_full;
   logic [ACC_W-1:0]            prod_ff;

   // accumulate stage
   logic                  fin_v_ff;
   logic [K_W-1:0]        fin_k_ff;
   logic                  fin_last_ff;
   logic                  fin_hit_ff;
   logic [ACC_W-1:0]      acc_ff;
   logic [ACC_W-1:0]      acc_round;

   assign prod_full = rd_data_ff * t1_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff  <= 1'b0;
         t2_v_ff  <= 1'b0;
         fin_v_ff <= 1'b0;
      end else begin
         t1_v_ff  <= issue;
         t2_v_ff  <= t1_v_ff;
         fin_v_ff <= t2_v_ff && (t2_j_ff == NBR_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         t1_j_ff    <= j_ff;
         t1_k_ff    <= k_ff;
         t1_last_ff <= (k_ff == k_last);
         t1_hit_ff  <= j_hit_ff;
         t1_w_ff    <= j_w_ff[j_ff];
      end
      if (t1_v_ff) begin
         t2_j_ff    <= t1_j_ff;
         t2_k_ff    <= t1_k_ff;
         t2_last_ff <= t1_last_ff;
         t2_hit_ff  <= t1_hit_ff;
         prod_ff    <= prod_full[ACC_W-1:0];
      end
      if (t2_v_ff) begin
         acc_ff      <= ((t2_j_ff == '0) ? '0 : acc_ff) + prod_ff;
         fin_k_ff    <= t2_k_ff;
         fin_last_ff <= t2_last_ff;
         fin_hit_ff  <= t2_hit_ff;
      end
   end

   // round half up from 32 fraction bits
   assign acc_round = acc_ff + {{(ACC_W-32){1'b0}}, 32'h8000_0000};

   // --------------------------------------------------------- result queue
   rsp_item_type          fifo_mem [FIFO_DEPTH];
   rsp_item_type          push_item;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic                  push;
   logic                  pop;

   assign push = fin_v_ff;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      push_item.sample_value   = acc_round[ACC_W-1:32];
      push_item.sample_channel = CHAN_W'(fin_k_ff);
      push_item.last_channel   = fin_last_ff;
      push_item.clamped        = fin_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         inflight_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
         inflight_ff <= inflight_ff + FIFO_CNT_W'(issue && (j_ff == '0))
                        - FIFO_CNT_W'(push);
      end
   end

   assign rsp_chan.valid          = (fifo_cnt_ff != '0);
   assign rsp_chan.sample_value   = fifo_mem[rd_ptr_ff].sample_value;
   assign rsp_chan.sample_channel = fifo_mem[rd_ptr_ff].sample_channel;
   assign rsp_chan.last_channel   = fifo_mem[rd_ptr_ff].last_channel;
   assign rsp_chan.clamped        = fifo_mem[rd_ptr_ff].clamped;

endmodule

// ----- verif/box_crop_bilinear_resample_checker.sv -----
// ----------------------------------------------------------------------------
// box_crop_bilinear_resample_checker
// watches both channels, predicts each blended sample and compares responses
// ----------------------------------------------------------------------------
module box_crop_bilinear_resample_checker
   import bcbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int CHANNELS   = 3,
   parameter int MAX_OUT    = 64
)(
   input  logic                   clock,
   input  logic                   reset,
   bcbr_req_if                    req_chan,
   bcbr_rsp_if                    rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                     mismatch_count,
   output int                     samples_pending
);

   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;

   logic [VALUE_W-1:0] image_mem [0:PIXELS*CHANNELS-1];
   logic [7:0]         image_width_reg;
   logic [7:0]         image_height_reg;
   logic [1:0]         channel_count_reg;
   logic [6:0]         out_width_reg;
   logic [6:0]         out_height_reg;
   rsp_item_type       expected_samples [$];

   assign samples_pending = expected_samples.size();

   function automatic longint floor_quotient(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint source_position(int unsigned start, int unsigned stop,
                                              int unsigned idx, int unsigned outn);
      longint stride;
      longint base;
      stride = longint'(stop) - longint'(start) - 1;
      base   = longint'(start) * 65536;
      if (outn < 2) return base;
      return base + floor_quotient(longint'(idx) * stride * 65536, longint'(outn) - 1);
   endfunction

   function automatic int unsigned clamp_coord(longint c, int unsigned size, ref bit hit);
      if (c < 0) begin
         hit = 1'b1;
         return 0;
      end
      if (c > longint'(size) - 1) begin
         hit = 1'b1;
         return size - 1;
      end
      return int'(c);
   endfunction

   task automatic split_position(input longint pos, input int unsigned size,
                                 output int unsigned lo, output int unsigned hi,
                                 output longint unsigned wlo, ref bit hit);
      longint fl;
      longint frac;
      fl   = floor_quotient(pos, 65536);
      frac = pos - fl * 65536;
      wlo  = (frac == 0) ? 0 : longint'(65536 - frac);
      lo   = clamp_coord(fl, size, hit);
      hi   = clamp_coord(fl + ((frac != 0) ? 1 : 0), size, hit);
   endtask

   function automatic longint unsigned pixel_value(int unsigned y, int unsigned x,
                                                   int unsigned w, int unsigned ch);
      int unsigned addr;
      addr = (y * w + x) * CHANNELS + ch;
      if (addr >= PIXELS * CHANNELS) return 0;
      return image_mem[addr];
   endfunction

   task automatic predict_samples();
      int unsigned       w, h, nch, ow, oh;
      int unsigned       y0, y1, x0, x1;
      longint unsigned   wy, wx, w00, w10, w01, w11, acc, v;
      bit                hit;
      rsp_item_type      item;
      w   = (image_width_reg == 0) ? 1 :
            (image_width_reg > MAX_WIDTH) ? MAX_WIDTH : image_width_reg;
      h   = (image_height_reg == 0) ? 1 :
            (image_height_reg > MAX_HEIGHT) ? MAX_HEIGHT : image_height_reg;
      nch = (channel_count_reg == 0) ? 1 :
            (channel_count_reg > CHANNELS) ? CHANNELS : channel_count_reg;
      ow  = (out_width_reg > MAX_OUT) ? MAX_OUT : out_width_reg;
      oh  = (out_height_reg > MAX_OUT) ? MAX_OUT : out_height_reg;
      hit = 1'b0;
      split_position(source_position(req_chan.box_top, req_chan.box_bottom,
                                     req_chan.out_row, oh), h, y0, y1, wy, hit);
      split_position(source_position(req_chan.box_left, req_chan.box_right,
                                     req_chan.out_col, ow), w, x0, x1, wx, hit);
      w00 = wx * wy;
      w10 = wx * (65536 - wy);
      w01 = (65536 - wx) * wy;
      w11 = (65536 - wx) * (65536 - wy);
      for (int unsigned k = 0; k < nch; k++) begin
         acc = w00 * pixel_value(y0, x0, w, k) + w10 * pixel_value(y1, x0, w, k)
             + w01 * pixel_value(y0, x1, w, k) + w11 * pixel_value(y1, x1, w, k);
         v = (acc + (64'd1 << 31)) >> 32;
         if (v > 64'hFFFF) v = 64'hFFFF;
         item.sample_value   = VALUE_W'(v);
         item.sample_channel = CHAN_W'(k);
         item.last_channel   = (k + 1 == nch);
         item.clamped        = hit;
         expected_samples = {expected_samples, item};
      end
   endtask

   task automatic check_sample();
      rsp_item_type exp_item;
      if (expected_samples.size() == 0) begin
         $error("response transaction with no sample expected");
         mismatch_count++;
         return;
      end
      exp_item = expected_samples.pop_front();
      if (rsp_chan.sample_value !== exp_item.sample_value) begin
         $error("sample_value expected %0d actual %0d",
                exp_item.sample_value, rsp_chan.sample_value);
         mismatch_count++;
      end
      if (rsp_chan.sample_channel !== exp_item.sample_channel) begin
         $error("sample_channel expected %0d actual %0d",
                exp_item.sample_channel, rsp_chan.sample_channel);
         mismatch_count++;
      end
      if (rsp_chan.last_channel !== exp_item.last_channel) begin
         $error("last_channel expected %0d actual %0d",
                exp_item.last_channel, rsp_chan.last_channel);
         mismatch_count++;
      end
      if (rsp_chan.clamped !== exp_item.clamped) begin
         $error("clamped expected %0d actual %0d", exp_item.clamped, rsp_chan.clamped);
         mismatch_count++;
      end
   endtask

   initial mismatch_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         image_width_reg   <= 8'd128;
         image_height_reg  <= 8'd128;
         channel_count_reg <= 2'd3;
         out_width_reg     <= 7'd16;
         out_height_reg    <= 7'd16;
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   image_width_reg   <= csr_write_data;
               CSR_IMAGE_HEIGHT:  image_height_reg  <= csr_write_data;
               CSR_CHANNEL_COUNT: channel_count_reg <= csr_write_data[1:0];
               CSR_OUT_WIDTH:     out_width_reg     <= csr_write_data[6:0];
               CSR_OUT_HEIGHT:    out_height_reg    <= csr_write_data[6:0];
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) check_sample();
         if (req_chan.valid && req_chan.ready) begin
            if (req_chan.operation == OP_WRITE) begin
               if (req_chan.write_channel < CHANNELS)
                  image_mem[req_chan.pixel_index * CHANNELS + req_chan.write_channel]
                     = req_chan.write_value;
            end else begin
               predict_samples();
            end
         end
      end
   end

endmodule

// ----- verif/box_crop_bilinear_resample_tb.sv -----
// ----------------------------------------------------------------------------
// box_crop_bilinear_resample_tb
// loads small images, then sends directed and random sample transactions
// across several register settings; the checker predicts every response
// ----------------------------------------------------------------------------
module box_crop_bilinear_resample_tb;
   import bcbr_pkg::*;

   // an index past the register list, which the block must ignore
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam int PHASE_COUNT = 9;
   // pixels loaded once; every setting below stays within them
   localparam int LOAD_PIXELS = 24;
   localparam int SAMPLES_PER_PHASE = 6;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;
   int                     mismatch_count;
   int                     samples_pending;
   int                     send_idle;
   int                     recv_idle;

   bcbr_req_if req_chan ();
   bcbr_rsp_if rsp_chan ();

   box_crop_bilinear_resample dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   box_crop_bilinear_resample_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .samples_pending  (samples_pending)
   );

   always #2 clock = ~clock;

   // receiver stalls at random, rate set per phase
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // one request transaction; the sender may leave gaps before it
   task automatic send_request(input logic op, input int pix, input int ch, input int val,
                               input int top, input int left, input int bottom,
                               input int right, input int row, input int col);
      while ($urandom_range(0, 99) < send_idle) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= op;
      req_chan.pixel_index   <= PIXEL_INDEX_W'(pix);
      req_chan.write_channel <= CHAN_W'(ch);
      req_chan.write_value   <= VALUE_W'(val);
      req_chan.box_top       <= TOP_W'(top);
      req_chan.box_left      <= TOP_W'(left);
      req_chan.box_bottom    <= BOTTOM_W'(bottom);
      req_chan.box_right     <= BOTTOM_W'(right);
      req_chan.out_row       <= OUT_POS_W'(row);
      req_chan.out_col       <= OUT_POS_W'(col);
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_write(input int pix, input int ch, input int val);
      send_request(OP_WRITE, pix, ch, val, $urandom_range(0, 127), $urandom_range(0, 127),
                   $urandom_range(0, 128), $urandom_range(0, 128),
                   $urandom_range(0, 63), $urandom_range(0, 63));
   endtask

   task automatic send_sample(input int top, input int left, input int bottom,
                              input int right, input int row, input int col);
      send_request(OP_SAMPLE, $urandom_range(0, 16383), $urandom_range(0, 3),
                   $urandom_range(0, 65535), top, left, bottom, right, row, col);
   endtask

   // let everything drain, then program the five registers
   task automatic program_phase(input int iw, input int ih, input int nch,
                                input int ow, input int oh);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (samples_pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_IMAGE_WIDTH;
      csr_write_data   <= CSR_DATA_W'(iw);
      @(negedge clock);
      csr_index        <= CSR_IMAGE_HEIGHT;
      csr_write_data   <= CSR_DATA_W'(ih);
      @(negedge clock);
      csr_index        <= CSR_CHANNEL_COUNT;
      csr_write_data   <= CSR_DATA_W'(nch);
      @(negedge clock);
      csr_index        <= CSR_OUT_WIDTH;
      csr_write_data   <= CSR_DATA_W'(ow);
      @(negedge clock);
      csr_index        <= CSR_OUT_HEIGHT;
      csr_write_data   <= CSR_DATA_W'(oh);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int iw, ih, nch, ow, oh, ew, eh;
      int top, left, bottom, right;
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_IMAGE_WIDTH;
      csr_write_data   = '0;
      send_idle        = 33;
      recv_idle        = 66;
      rsp_chan.ready   = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.operation     = OP_WRITE;
      req_chan.pixel_index   = '0;
      req_chan.write_channel = '0;
      req_chan.write_value   = '0;
      req_chan.box_top       = '0;
      req_chan.box_left      = '0;
      req_chan.box_bottom    = '0;
      req_chan.box_right     = '0;
      req_chan.out_row       = '0;
      req_chan.out_col       = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // load every entry a sample could touch under any setting below
      for (int p = 0; p < LOAD_PIXELS; p++)
         for (int c = 0; c < 3; c++)
            send_write(p, c, $urandom_range(0, 65535));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // idling pattern: sender-light first, then receiver-light, then none
         if (phase == 3) begin
            send_idle = 66;
            recv_idle = 33;
         end else if (phase == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         case (phase)
            0: begin
               // widest loaded row, a single row; shortest patch in y that still divides
               iw = 24; ih = 1; nch = 3; ow = 64; oh = 2;
            end
            1: begin
               // zero width and channel count, oversized patch
               iw = 0; ih = 24; nch = 0; ow = 127; oh = 0;
            end
            2: begin
               iw = 5; ih = 4; nch = 2; ow = 1; oh = 64;
            end
            default: begin
               iw  = $urandom_range(0, 6);
               ih  = $urandom_range(0, 4);
               nch = $urandom_range(0, 3);
               ow  = $urandom_range(0, 127);
               oh  = $urandom_range(0, 127);
            end
         endcase
         program_phase(iw, ih, nch, ow, oh);
         if (phase == 1) begin
            // the spare register index must leave the settings alone
            @(negedge clock);
            csr_write_enable <= 1'b1;
            csr_index        <= CSR_SPARE_INDEX;
            csr_write_data   <= 8'hFF;
            @(negedge clock);
            csr_write_enable <= 1'b0;
         end
         ew = (iw == 0) ? 1 : (iw > 128) ? 128 : iw;
         eh = (ih == 0) ? 1 : (ih > 128) ? 128 : ih;

         if (phase == 0) begin
            // ignored channel, topmost pixel index, extreme values
            send_write(5, 3, 16'h1234);
            send_write(16383, 0, 16'hFFFF);
            send_write(0, 0, 16'hFFFF);
            send_write(23, 2, 16'h0000);
            send_sample(0, 0, 128, 128, 0, 0);
            send_sample(0, 0, 128, 128, 1, 63);
            send_sample(127, 127, 0, 0, 63, 63);   // inverted box
            send_sample(5, 7, 5, 7, 1, 1);         // empty box
            send_sample(0, 127, 1, 128, 0, 0);
            send_sample(0, 0, 128, 128, 63, 31);   // row past the patch
            send_sample(3, 10, 9, 90, 1, 17);
            send_sample(0, 64, 1, 65, 0, 0);
            send_sample(0, 0, 0, 0, 0, 0);
         end

         for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 70) begin
               // box inside the loaded image, position inside the patch
               top    = $urandom_range(0, eh - 1);
               bottom = $urandom_range(top + 1, eh);
               left   = $urandom_range(0, ew - 1);
               right  = $urandom_range(left + 1, ew);
               send_sample(top, left, bottom, right,
                           $urandom_range(0, (oh > 1 && oh < 64) ? oh - 1 : 63),
                           $urandom_range(0, (ow > 1 && ow < 64) ? ow - 1 : 63));
            end else begin
               send_sample($urandom_range(0, 127), $urandom_range(0, 127),
                           $urandom_range(0, 128), $urandom_range(0, 128),
                           $urandom_range(0, 63), $urandom_range(0, 63));
            end
         end
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (samples_pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (mismatch_count == 0 && samples_pending == 0) begin
         $display("[box_crop_bilinear_resample] OK");
      end else begin
         $display("[box_crop_bilinear_resample] ERROR");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #8000000;
      $display("[box_crop_bilinear_resample] ERROR");
      $finish;
   end

endmodule
